// ===== sv/ijc_pkg.sv =====
// ----------------------------------------------------------------------------
// ijc_pkg: shared types and constants for the interrupt and keypad controller
// Holds the operation codes, source vectors, state and result structs and the
// display status line decode.
// ----------------------------------------------------------------------------
package ijc_pkg;

   localparam int NUM_SRC = 5;

   // Operation codes carried in the mode field
   typedef enum logic [2:0] {
      MODE_POLL   = 3'd0,
      MODE_ACK    = 3'd1,
      MODE_WRFLAG = 3'd2,
      MODE_WREN   = 3'd3,
      MODE_RAISE  = 3'd4,
      MODE_KEYPAD = 3'd5
   } mode_type;

   // Source bits in the flag and enable registers
   localparam logic [7:0] SRC_VBLANK = 8'h01;
   localparam logic [7:0] SRC_STAT   = 8'h02;
   localparam logic [7:0] SRC_KEYPAD = 8'h10;
   localparam logic [7:0] SRC_MASK   = 8'h1F;

   // Keypad register: reset value and bits forced high by a select write
   localparam logic [7:0] KEYPAD_RESET = 8'hFF;
   localparam logic [7:0] KEYPAD_FORCE = 8'hCF;
   localparam logic [3:0] KEYPAD_LINES = 4'hF;

   // Status byte: coincidence check bits
   localparam logic [7:0] STAT_COINC = 8'h44;

   // Handler address by source, highest priority first
   localparam logic [6:0] VECTOR_TABLE [NUM_SRC] = '{7'h40, 7'h48, 7'h50, 7'h58, 7'h60};

   // One request as it travels through the input register
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] data;
      logic       vblank_now;
      logic       lcd_enabled;
      logic [7:0] stat_value;
      logic [7:0] buttons;
   } req_type;

   // Architectural state of the controller
   typedef struct packed {
      logic [7:0]         flags;
      logic [7:0]         enables;
      logic [7:0]         keypad;
      logic [NUM_SRC-1:0] last_source;
      logic               prev_line;
   } state_type;

   // One result
   typedef struct packed {
      logic       pending;
      logic [6:0] vector_addr;
      logic [2:0] pending_count;
      logic [7:0] flags_value;
      logic [7:0] keypad_value;
      logic       wake;
   } result_type;

   // Display status line from the status byte
   function automatic logic status_line(input logic [7:0] stat);
      logic line;
      line = 1'b0;
      if ((stat & STAT_COINC) == STAT_COINC) begin
         line = 1'b1;
      end else begin
         case (stat[1:0])
            2'd0:    line = stat[3];
            2'd1:    line = stat[4];
            2'd2:    line = stat[5];
            default: line = 1'b0;
         endcase
      end
      return line;
   endfunction

endpackage

// ===== sv/interrupt_and_joypad_controller_top.sv =====
// ----------------------------------------------------------------------------
// interrupt_and_joypad_controller_top: five-source interrupt controller
// Input register, single-pass execution and result register around the flag,
// enable, keypad, last-source and status-line state.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_ready; each carries a mode (poll,
//   acknowledge, flag write, enable write, raise, keypad select write) and
//   its operands. Every request gives exactly one result on rsp_valid/
//   rsp_ready, in request order.
//   An accepted request passes through the input register, then through
//   execution into the result register, which drives rsp_valid.
//   Throughput: one request per cycle while rsp_ready stays high; the
//   execution logic is combinational, so a request may enter every cycle.
//   State is updated when a request moves from the input register into the
//   result register, so results follow the request order exactly.
//   Reset clears flags, enables, last source and status line and sets the
//   keypad register to all lines released.
//   When the receiver stalls, the result register holds and the input
//   register takes one more request; req_ready then drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module interrupt_and_joypad_controller_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_data,
   input  logic       req_vblank_now,
   input  logic       req_lcd_enabled,
   input  logic [7:0] req_stat_value,
   input  logic [7:0] req_buttons,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pending,
   output logic [6:0] rsp_vector_addr,
   output logic [2:0] rsp_pending_count,
   output logic [7:0] rsp_flags_value,
   output logic [7:0] rsp_keypad_value,
   output logic       rsp_wake
);
   import ijc_pkg::*;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   req_type    s1_req_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type exec_res;
   logic       advance;
   logic       take;

   // Move a request forward when the result register is free or draining
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;

   ijc_exec u_exec (
      .req (s1_req_ff),
      .cur (state_ff),
      .nxt (state_in),
      .res (exec_res)
   );

   // Track occupancy of both registers
   always_comb begin
      s1_valid_in  = take || (s1_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{flags: 8'h00, enables: 8'h00, keypad: KEYPAD_RESET,
                           last_source: '0, prev_line: 1'b0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture request payload and result payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_req_ff <= '{mode: req_mode, data: req_data, vblank_now: req_vblank_now,
                        lcd_enabled: req_lcd_enabled, stat_value: req_stat_value,
                        buttons: req_buttons};
      end
      if (advance) begin
         out_res_ff <= exec_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pending       = out_res_ff.pending;
   assign rsp_vector_addr   = out_res_ff.vector_addr;
   assign rsp_pending_count = out_res_ff.pending_count;
   assign rsp_flags_value   = out_res_ff.flags_value;
   assign rsp_keypad_value  = out_res_ff.keypad_value;
   assign rsp_wake          = out_res_ff.wake;

`ifndef SYNTHESIS
   // Pending results carry a vector and a nonzero count
   a_pending_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pending) |-> (rsp_pending_count != 3'd0 && rsp_vector_addr != 7'd0))
      else $error("pending result without vector or count");

   // Results with nothing pending report zero vector and count
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pending) |-> (rsp_pending_count == 3'd0 && rsp_vector_addr == 7'd0))
      else $error("vector or count without pending");

   // The last dispatched source is a single source or none
   a_last_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(state_ff.last_source))
      else $error("last source has more than one bit");

   // The two upper keypad bits, forced high by a select write, never drop
   a_keypad_high: assert property (@(posedge clock) disable iff (reset)
      state_ff.keypad[7:6] == 2'b11)
      else $error("keypad upper bits low");

   // State only changes when a request executes
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a request");
`endif

endmodule

// ===== sv/ijc_exec.sv =====
// ----------------------------------------------------------------------------
// ijc_exec: single-request execution logic
// Computes the next controller state and the result for one request from the
// current state.
// ----------------------------------------------------------------------------
module ijc_exec (
   input  ijc_pkg::req_type    req,
   input  ijc_pkg::state_type  cur,
   output ijc_pkg::state_type  nxt,
   output ijc_pkg::result_type res
);
   import ijc_pkg::*;

   logic [7:0]         poll_flags;
   logic               cur_line;
   logic [NUM_SRC-1:0] pend_bits;
   logic [NUM_SRC-1:0] lowest;
   logic [2:0]         count;
   logic [6:0]         vector;
   logic [7:0]         sel_byte;
   logic [3:0]         pressed;
   logic [3:0]         prev_lines;
   logic [3:0]         lines;

   // Poll: latch vertical blank and a rising status line, then prioritize
   always_comb begin
      cur_line   = status_line(req.stat_value);
      poll_flags = cur.flags;
      if (req.vblank_now) begin
         poll_flags = poll_flags | SRC_VBLANK;
      end
      if (req.lcd_enabled && !cur.prev_line && cur_line) begin
         poll_flags = poll_flags | SRC_STAT;
      end
      pend_bits = poll_flags[NUM_SRC-1:0] & cur.enables[NUM_SRC-1:0];
      lowest    = pend_bits & (~pend_bits + 1'b1);
      count     = '0;
      vector    = '0;
      for (int i = NUM_SRC - 1; i >= 0; i--) begin
         if (pend_bits[i]) begin
            count  = count + 3'd1;
            vector = VECTOR_TABLE[i];
         end
      end
   end

   // Keypad select write: pull selected lines low, flag a falling line
   always_comb begin
      sel_byte   = req.data | KEYPAD_FORCE;
      prev_lines = cur.keypad[3:0];
      pressed    = (sel_byte[5] ? 4'h0 : req.buttons[7:4])
                 | (sel_byte[4] ? 4'h0 : req.buttons[3:0]);
      lines      = sel_byte[3:0] & ~pressed;
   end

   // Apply the operation
   always_comb begin
      nxt = cur;
      res = '0;
      case (mode_type'(req.mode))
         MODE_POLL: begin
            nxt.flags = poll_flags;
            if (req.lcd_enabled) begin
               nxt.prev_line = cur_line;
            end
            if (pend_bits != '0) begin
               nxt.last_source   = lowest;
               res.pending       = 1'b1;
               res.vector_addr   = vector;
               res.pending_count = count;
            end
         end
         MODE_ACK: begin
            nxt.flags = cur.flags & ~{{(8-NUM_SRC){1'b0}}, cur.last_source};
         end
         MODE_WRFLAG: begin
            nxt.flags = req.data;
         end
         MODE_WREN: begin
            nxt.enables = req.data;
         end
         MODE_RAISE: begin
            nxt.flags = cur.flags | req.data;
         end
         MODE_KEYPAD: begin
            nxt.keypad = {sel_byte[7:4], lines};
            if ((pressed & prev_lines) != 4'h0) begin
               nxt.flags = cur.flags | SRC_KEYPAD;
            end
            res.wake = (lines != KEYPAD_LINES);
         end
         default: begin
            nxt = cur;
         end
      endcase
      res.flags_value  = nxt.flags;
      res.keypad_value = nxt.keypad;
   end

endmodule

// ===== sim/ijc_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ijc_result_checker: result predictor and comparator for the controller
// Watches the request and result channels, tracks the flag, enable, keypad,
// last-source and status-line state for every accepted request, and compares
// each returned result field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module ijc_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_data,
   input  logic       req_vblank_now,
   input  logic       req_lcd_enabled,
   input  logic [7:0] req_stat_value,
   input  logic [7:0] req_buttons,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_pending,
   input  logic [6:0] rsp_vector_addr,
   input  logic [2:0] rsp_pending_count,
   input  logic [7:0] rsp_flags_value,
   input  logic [7:0] rsp_keypad_value,
   input  logic       rsp_wake,
   output int         mismatch_count,
   output int         due_count
);
   import ijc_pkg::*;

   // Shadow copy of the controller state
   logic [7:0]         shadow_flags;
   logic [7:0]         shadow_enables;
   logic [7:0]         shadow_keypad;
   logic [NUM_SRC-1:0] shadow_last_src;
   logic               shadow_prev_line;

   result_type due_results[$];
   int         mismatches;

   initial begin
      mismatch_count = 0;
      due_count      = 0;
      mismatches     = 0;
   end

   // Status line: coincidence wins, else the enable picked by the mode bits
   function automatic logic stat_line_high(input logic [7:0] stat);
      if (stat[2] && stat[6]) begin
         return 1'b1;
      end
      return (stat[1:0] != 2'd3) && stat[3 + stat[1:0]];
   endfunction

   // Apply one request to the shadow state and work out its result
   task automatic run_controller_op(
      input  logic [2:0] mode,
      input  logic [7:0] data,
      input  logic       vbl,
      input  logic       lcd,
      input  logic [7:0] stat,
      input  logic [7:0] btn,
      output result_type res
   );
      logic               line;
      logic [NUM_SRC-1:0] live;
      logic [3:0]         prev_lines;
      logic [3:0]         pulled;
      int                 hits;

      res  = '0;
      hits = 0;
      case (mode)
         MODE_POLL: begin
            if (vbl) begin
               shadow_flags = shadow_flags | SRC_VBLANK;
            end
            if (lcd) begin
               line = stat_line_high(stat);
               if (!shadow_prev_line && line) begin
                  shadow_flags = shadow_flags | SRC_STAT;
               end
               shadow_prev_line = line;
            end
            live = shadow_flags[NUM_SRC-1:0] & shadow_enables[NUM_SRC-1:0];
            // walk from lowest priority up so the highest one lands last
            for (int i = NUM_SRC - 1; i >= 0; i--) begin
               if (live[i]) begin
                  hits++;
                  res.vector_addr = VECTOR_TABLE[i];
                  shadow_last_src = NUM_SRC'(1 << i);
               end
            end
            res.pending       = |live;
            res.pending_count = 3'(hits);
         end
         MODE_ACK: begin
            shadow_flags = shadow_flags & ~{3'b000, shadow_last_src};
         end
         MODE_WRFLAG: begin
            shadow_flags = data;
         end
         MODE_WREN: begin
            shadow_enables = data;
         end
         MODE_RAISE: begin
            shadow_flags = shadow_flags | data;
         end
         MODE_KEYPAD: begin
            prev_lines    = shadow_keypad[3:0];
            shadow_keypad = data | KEYPAD_FORCE;
            pulled        = (shadow_keypad[5] ? 4'h0 : btn[7:4]) |
                            (shadow_keypad[4] ? 4'h0 : btn[3:0]);
            // a line that was released and is now pulled low raises keypad
            if ((pulled & prev_lines) != 4'h0) begin
               shadow_flags = shadow_flags | SRC_KEYPAD;
            end
            shadow_keypad[3:0] = shadow_keypad[3:0] & ~pulled;
            res.wake = (shadow_keypad[3:0] != KEYPAD_LINES);
         end
         default: begin
         end
      endcase
      res.flags_value  = shadow_flags;
      res.keypad_value = shadow_keypad;
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, field, want, got);
      end
   endtask

   // Compare returned results, then predict newly accepted requests
   always @(posedge clock) begin
      result_type want;
      result_type res;

      if (reset) begin
         shadow_flags     = '0;
         shadow_enables   = '0;
         shadow_keypad    = KEYPAD_RESET;
         shadow_last_src  = '0;
         shadow_prev_line = 1'b0;
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with no request outstanding, expected none, actual flags 'h%0h",
                        $time, rsp_flags_value);
            end else begin
               want = due_results.pop_front();
               check_field("pending",       want.pending,       rsp_pending);
               check_field("vector_addr",   want.vector_addr,   rsp_vector_addr);
               check_field("pending_count", want.pending_count, rsp_pending_count);
               check_field("flags_value",   want.flags_value,   rsp_flags_value);
               check_field("keypad_value",  want.keypad_value,  rsp_keypad_value);
               check_field("wake",          want.wake,          rsp_wake);
            end
         end
         if (req_valid && req_ready) begin
            run_controller_op(req_mode, req_data, req_vblank_now, req_lcd_enabled,
                              req_stat_value, req_buttons, res);
            due_results.push_back(res);
         end
      end
      mismatch_count <= mismatches;
      due_count      <= due_results.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the interrupt and keypad controller
// Drives a directed pass over every operation and corner of the status line
// and keypad logic, then random bursts of requests against a stalling
// receiver with one long hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import ijc_pkg::*;

   localparam int         RANDOM_REQUESTS = 525;
   localparam int         HOLD_OFF_CYCLES = 80;
   localparam int         HOLD_OFF_AFTER  = 120;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         LIMIT_CYCLES    = 200000;
   // mode codes the block leaves unused
   localparam logic [2:0] MODE_SPARE_A    = 3'd6;
   localparam logic [2:0] MODE_SPARE_B    = 3'd7;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [2:0] req_mode          = MODE_POLL;
   logic [7:0] req_data          = '0;
   logic       req_vblank_now    = 1'b0;
   logic       req_lcd_enabled   = 1'b0;
   logic [7:0] req_stat_value    = '0;
   logic [7:0] req_buttons       = '0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic       rsp_pending;
   logic [6:0] rsp_vector_addr;
   logic [2:0] rsp_pending_count;
   logic [7:0] rsp_flags_value;
   logic [7:0] rsp_keypad_value;
   logic       rsp_wake;
   int         mismatch_count;
   int         due_count;
   int         cycle_count       = 0;

   interrupt_and_joypad_controller_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_data          (req_data),
      .req_vblank_now    (req_vblank_now),
      .req_lcd_enabled   (req_lcd_enabled),
      .req_stat_value    (req_stat_value),
      .req_buttons       (req_buttons),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pending       (rsp_pending),
      .rsp_vector_addr   (rsp_vector_addr),
      .rsp_pending_count (rsp_pending_count),
      .rsp_flags_value   (rsp_flags_value),
      .rsp_keypad_value  (rsp_keypad_value),
      .rsp_wake          (rsp_wake)
   );

   ijc_result_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_data          (req_data),
      .req_vblank_now    (req_vblank_now),
      .req_lcd_enabled   (req_lcd_enabled),
      .req_stat_value    (req_stat_value),
      .req_buttons       (req_buttons),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pending       (rsp_pending),
      .rsp_vector_addr   (rsp_vector_addr),
      .rsp_pending_count (rsp_pending_count),
      .rsp_flags_value   (rsp_flags_value),
      .rsp_keypad_value  (rsp_keypad_value),
      .rsp_wake          (rsp_wake),
      .mismatch_count    (mismatch_count),
      .due_count         (due_count)
   );

   // Free-running clock
   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_request(
      input logic [2:0] mode,
      input logic [7:0] data,
      input logic       vbl,
      input logic       lcd,
      input logic [7:0] stat,
      input logic [7:0] btn
   );
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_data        <= data;
      req_vblank_now  <= vbl;
      req_lcd_enabled <= lcd;
      req_stat_value  <= stat;
      req_buttons     <= btn;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Receiver: random stalls, plus one long hold-off to back up the block
   initial begin
      int  run_len;
      int  taken;
      bit  held;

      taken = 0;
      held  = 1'b0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!held && taken >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            run_len = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 24);
            repeat (run_len) begin
               @(posedge clock);
               if (rsp_valid) begin
                  taken++;
               end
            end
            if ($urandom_range(0, 3) != 0) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int         burst_left;
      int         gap;
      int         pick;
      logic [2:0] mode;
      logic [7:0] data;
      logic [7:0] btn;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // nothing pending straight out of reset
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_WREN,   8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
      // vertical blank together with a status rising edge
      send_request(MODE_POLL,   8'h00, 1'b1, 1'b1, 8'h08, 8'h00);
      // acknowledge twice clears the same source again
      send_request(MODE_ACK,    8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_ACK,    8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      // line stays high: no new edge
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b1, 8'h08, 8'h00);
      send_request(MODE_ACK,    8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      // display off keeps the previous line
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      // status mode three without coincidence stays low
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b1, 8'h7B, 8'h00);
      // coincidence in mode three drives the line high
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b1, 8'h47, 8'h00);
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b1, 8'h22, 8'h00);
      // every source pending at once
      send_request(MODE_WRFLAG, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_WRFLAG, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_RAISE,  8'h84, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_RAISE,  8'h08, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
      // only bits outside dispatch enabled: nothing pending despite flags
      send_request(MODE_WREN,   8'hE0, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_POLL,   8'h00, 1'b1, 1'b0, 8'h00, 8'h00);
      // keypad: both groups, no group, action only, direction only
      send_request(MODE_KEYPAD, 8'h00, 1'b0, 1'b0, 8'h00, 8'hFF);
      send_request(MODE_KEYPAD, 8'hFF, 1'b0, 1'b0, 8'h00, 8'hFF);
      send_request(MODE_KEYPAD, 8'h10, 1'b0, 1'b0, 8'h00, 8'hA0);
      send_request(MODE_KEYPAD, 8'h20, 1'b0, 1'b0, 8'h00, 8'h05);
      // unused modes leave the state alone
      send_request(MODE_SPARE_A, 8'hAA, 1'b1, 1'b1, 8'hFF, 8'hFF);
      send_request(MODE_SPARE_B, 8'h55, 1'b1, 1'b1, 8'hFF, 8'hFF);
      // keypad source dispatch
      send_request(MODE_WREN,   8'h10, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MODE_POLL,   8'h00, 1'b0, 1'b0, 8'h00, 8'h00);

      // random requests in bursts with gaps
      burst_left = 0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            mode = MODE_POLL;
         end else if (pick < 45) begin
            mode = MODE_ACK;
         end else if (pick < 52) begin
            mode = MODE_WRFLAG;
         end else if (pick < 60) begin
            mode = MODE_WREN;
         end else if (pick < 70) begin
            mode = MODE_RAISE;
         end else if (pick < 94) begin
            mode = MODE_KEYPAD;
         end else if (pick < 97) begin
            mode = MODE_SPARE_A;
         end else begin
            mode = MODE_SPARE_B;
         end

         // single-bit raises keep the flag register from saturating
         data = 8'($urandom_range(0, 255));
         if (mode == MODE_RAISE && $urandom_range(0, 1) == 0) begin
            data = 8'(1 << $urandom_range(0, 7));
         end
         btn = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         send_request(mode, data,
                      ($urandom_range(0, 9) < 3),
                      ($urandom_range(0, 9) < 8),
                      8'($urandom_range(0, 255)),
                      btn);
      end
      req_valid <= 1'b0;

      // let the checker count the last request, then drain outstanding results
      @(posedge clock);
      while (due_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ijc_pkg.sv
sv/ijc_exec.sv
sv/interrupt_and_joypad_controller_top.sv
sim/ijc_result_checker.sv
sim/testbench.sv
